// ===== hdl/csv3_pkg.sv =====
`default_nettype none

package csv3_pkg;

  // Phases of the base-0 integer check on the second and third fields.
  typedef enum logic [3:0] {
    CK_LEAD   = 4'd0,
    CK_SIGN   = 4'd1,
    CK_ZERO   = 4'd2,
    CK_PREFIX = 4'd3,
    CK_OCT    = 4'd4,
    CK_DEC    = 4'd5,
    CK_HEX    = 4'd6,
    CK_TRAIL  = 4'd7,
    CK_BAD    = 4'd8
  } ck_phase_e;

  // Phases of the plain decimal reading.
  typedef enum logic [1:0] {
    DP_LEAD   = 2'd0,
    DP_SIGN   = 2'd1,
    DP_DIGITS = 2'd2,
    DP_DONE   = 2'd3
  } dec_phase_e;

  localparam logic [7:0]  CH_NUL    = 8'h00;
  localparam logic [7:0]  CH_COMMA  = 8'h2C;
  localparam logic [7:0]  CH_MINUS  = 8'h2D;
  localparam logic [7:0]  CH_PLUS   = 8'h2B;
  localparam logic [7:0]  CH_ZERO   = 8'h30;
  localparam logic [2:0]  TOK_LAST  = 3'd3;
  localparam logic [2:0]  TOK_OVER  = 3'd4;
  localparam logic [31:0] MAG_LIMIT = 32'h8000_0000;

  typedef struct packed {
    logic signed [31:0] temperature;
    logic signed [31:0] min_time;
    logic signed [31:0] max_time;
    logic               line_ok;
  } csv3_result_t;

endpackage

`default_nettype wire

// ===== hdl/csv3_in_if.sv =====
`default_nettype none

interface csv3_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       end_of_line;

  modport source (output valid, output ch, output end_of_line, input ready);
  modport sink   (input valid, input ch, input end_of_line, output ready);
endinterface

`default_nettype wire

// ===== hdl/csv3_out_if.sv =====
`default_nettype none

interface csv3_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] temperature;
  logic signed [31:0] min_time;
  logic signed [31:0] max_time;
  logic               line_ok;

  modport source (output valid, output temperature, output min_time, output max_time,
                  output line_ok, input ready);
  modport sink   (input valid, input temperature, input min_time, input max_time,
                  input line_ok, output ready);
endinterface

`default_nettype wire

// ===== hdl/csv3_parse_core.sv =====
`default_nettype none

module csv3_parse_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  logic [7:0]            ch_i,
  input  logic                  eol_i,
  output csv3_pkg::csv3_result_t result_o,
  output logic                  result_valid_o
);
  import csv3_pkg::*;

  logic [2:0]  tok_q, tok_d;
  logic        in_tok_q, in_tok_d;
  ck_phase_e   ck_q, ck_d;
  dec_phase_e  dp_q, dp_d;
  logic        neg_q, neg_d;
  logic [31:0] acc_q, acc_d;
  logic [31:0] first_q, first_d;
  logic [31:0] second_q, second_d;
  logic        err_q, err_d;
  logic        ended_q, ended_d;
  logic        close_req;
  logic        line_ok;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_dec(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h39;
  endfunction

  function automatic logic is_oct(input logic [7:0] c);
    return c >= 8'h30 && c <= 8'h37;
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return is_dec(c) || (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
  endfunction

  function automatic ck_phase_e next_check(input ck_phase_e p, input logic [7:0] c,
                                           input logic no_minus);
    ck_phase_e n;
    n = CK_BAD;
    case (p)
      CK_LEAD: begin
        if (is_ws(c)) n = CK_LEAD;
        else if (c == CH_MINUS) n = no_minus ? CK_BAD : CK_SIGN;
        else if (c == CH_PLUS) n = CK_SIGN;
        else if (c == CH_ZERO) n = CK_ZERO;
        else if (is_dec(c)) n = CK_DEC;
      end
      CK_SIGN: begin
        if (c == CH_ZERO) n = CK_ZERO;
        else if (is_dec(c)) n = CK_DEC;
      end
      CK_ZERO: begin
        if (c == 8'h78 || c == 8'h58) n = CK_PREFIX;
        else if (is_oct(c)) n = CK_OCT;
        else if (is_ws(c)) n = CK_TRAIL;
      end
      CK_PREFIX: begin
        if (is_hex(c)) n = CK_HEX;
      end
      CK_OCT: begin
        if (is_oct(c)) n = CK_OCT;
        else if (is_ws(c)) n = CK_TRAIL;
      end
      CK_DEC: begin
        if (is_dec(c)) n = CK_DEC;
        else if (is_ws(c)) n = CK_TRAIL;
      end
      CK_HEX: begin
        if (is_hex(c)) n = CK_HEX;
        else if (is_ws(c)) n = CK_TRAIL;
      end
      CK_TRAIL: begin
        if (is_ws(c)) n = CK_TRAIL;
      end
      default: n = CK_BAD;
    endcase
    return n;
  endfunction

  // The magnitude is held at 2^31 at most, which is enough to saturate either sign.
  function automatic logic [31:0] acc_step(input logic [31:0] acc, input logic [7:0] c);
    logic [35:0] t;
    t = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + {32'd0, c[3:0]};
    return (t > {4'd0, MAG_LIMIT}) ? MAG_LIMIT : t[31:0];
  endfunction

  function automatic logic [31:0] sat(input logic neg, input logic [31:0] acc);
    logic [31:0] v;
    if (neg) v = (acc >= MAG_LIMIT) ? MAG_LIMIT : (32'd0 - acc);
    else v = (acc >= MAG_LIMIT) ? (MAG_LIMIT - 32'd1) : acc;
    return v;
  endfunction

  always_comb begin
    tok_d     = tok_q;
    in_tok_d  = in_tok_q;
    ck_d      = ck_q;
    dp_d      = dp_q;
    neg_d     = neg_q;
    acc_d     = acc_q;
    first_d   = first_q;
    second_d  = second_q;
    err_d     = err_q;
    ended_d   = ended_q;
    close_req = 1'b0;

    if (!ended_q) begin
      if (ch_i == CH_NUL) begin
        ended_d   = 1'b1;
        close_req = in_tok_q;
      end else if (ch_i == CH_COMMA) begin
        close_req = in_tok_q;
      end else begin
        if (!in_tok_q) begin
          in_tok_d = 1'b1;
          if (tok_q >= TOK_LAST) begin
            tok_d = TOK_OVER;
            err_d = 1'b1;
          end else begin
            tok_d = tok_q + 3'd1;
            dp_d  = DP_LEAD;
            ck_d  = CK_LEAD;
            neg_d = 1'b0;
            acc_d = '0;
          end
        end
        if (tok_d >= 3'd1 && tok_d <= TOK_LAST) begin
          case (dp_d)
            DP_LEAD: begin
              if (is_ws(ch_i)) begin
                dp_d = DP_LEAD;
              end else if (ch_i == CH_PLUS) begin
                dp_d = DP_SIGN;
              end else if (ch_i == CH_MINUS) begin
                neg_d = 1'b1;
                dp_d  = DP_SIGN;
              end else if (is_dec(ch_i)) begin
                acc_d = {28'd0, ch_i[3:0]};
                dp_d  = DP_DIGITS;
              end else begin
                dp_d = DP_DONE;
              end
            end
            DP_SIGN: begin
              if (is_dec(ch_i)) begin
                acc_d = {28'd0, ch_i[3:0]};
                dp_d  = DP_DIGITS;
              end else begin
                dp_d = DP_DONE;
              end
            end
            DP_DIGITS: begin
              if (is_dec(ch_i)) acc_d = acc_step(acc_d, ch_i);
              else dp_d = DP_DONE;
            end
            default: dp_d = DP_DONE;
          endcase
          if (tok_d >= 3'd2) begin
            ck_d = next_check(ck_d, ch_i, tok_d == TOK_LAST);
            if (ck_d == CK_BAD) err_d = 1'b1;
          end
        end
      end
    end

    // The end of the line closes a token that is still open.
    if (eol_i && in_tok_d) close_req = 1'b1;

    if (close_req) begin
      in_tok_d = 1'b0;
      if (tok_d == 3'd1) begin
        first_d = sat(neg_d, acc_d);
      end else if (tok_d == 3'd2 || tok_d == TOK_LAST) begin
        if (ck_d == CK_LEAD || ck_d == CK_SIGN || ck_d == CK_PREFIX || ck_d == CK_BAD) begin
          err_d = 1'b1;
        end
        if (tok_d == 3'd2) second_d = sat(neg_d, acc_d);
      end
    end

    line_ok = !err_d && (tok_d == TOK_LAST);
    result_o.temperature = line_ok ? first_d : '0;
    result_o.min_time    = line_ok ? second_d : '0;
    result_o.max_time    = line_ok ? sat(neg_d, acc_d) : '0;
    result_o.line_ok     = line_ok;
  end

  assign result_valid_o = step_i && eol_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q    <= '0;
      in_tok_q <= 1'b0;
      ck_q     <= CK_LEAD;
      dp_q     <= DP_LEAD;
      neg_q    <= 1'b0;
      acc_q    <= '0;
      first_q  <= '0;
      second_q <= '0;
      err_q    <= 1'b0;
      ended_q  <= 1'b0;
    end else if (step_i) begin
      if (eol_i) begin
        tok_q    <= '0;
        in_tok_q <= 1'b0;
        ck_q     <= CK_LEAD;
        dp_q     <= DP_LEAD;
        neg_q    <= 1'b0;
        acc_q    <= '0;
        first_q  <= '0;
        second_q <= '0;
        err_q    <= 1'b0;
        ended_q  <= 1'b0;
      end else begin
        tok_q    <= tok_d;
        in_tok_q <= in_tok_d;
        ck_q     <= ck_d;
        dp_q     <= dp_d;
        neg_q    <= neg_d;
        acc_q    <= acc_d;
        first_q  <= first_d;
        second_q <= second_d;
        err_q    <= err_d;
        ended_q  <= ended_d;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/csv3_three_integer_parser_unit.sv =====
// Parser for one comma-separated text line that carries three integer fields.
// in_i takes one byte of the line per beat; end_of_line marks its last byte.
// out_o gives one beat per line: the decimal readings of the three fields,
// saturated to signed 32 bits, and line_ok. When line_ok is low the three
// values are zero. Bytes after a zero byte are ignored up to the end of line.
// Throughput is one byte per cycle except while a line's last byte waits for
// the result register. Each byte is first held in an input register and from
// there updates the line state; this update is the single stage of parsing
// logic. The step that takes a line's last byte loads the result register.
// While the result register is full and out_o is stalled, bytes that are not
// the last of a line still flow through; the last byte of the next line
// waits in the input register, and in_i.ready drops once that register is
// occupied by it.
// Reset (rst_ni low, asynchronous) empties both registers and clears the
// line state, so the next byte starts a new line.
`default_nettype none

module csv_three_integer_parser_unit (
  input  logic       clk_i,
  input  logic       rst_ni,
  csv3_in_if.sink    in_i,
  csv3_out_if.source out_o
);
  import csv3_pkg::*;

  logic         in_valid_q;
  logic [7:0]   ch_q;
  logic         eol_q;
  logic         res_valid_q;
  csv3_result_t result_q;
  csv3_result_t core_result;
  logic         core_valid;
  logic         res_free;
  logic         step;

  assign res_free   = !res_valid_q || out_o.ready;
  assign step       = in_valid_q && (!eol_q || res_free);
  assign in_i.ready = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      ch_q  <= in_i.ch;
      eol_q <= in_i.end_of_line;
    end
  end

  csv3_parse_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (step),
    .ch_i           (ch_q),
    .eol_i          (eol_q),
    .result_o       (core_result),
    .result_valid_o (core_valid)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (res_free) begin
      res_valid_q <= core_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (core_valid) begin
      result_q <= core_result;
    end
  end

  assign out_o.valid       = res_valid_q;
  assign out_o.temperature = result_q.temperature;
  assign out_o.min_time    = result_q.min_time;
  assign out_o.max_time    = result_q.max_time;
  assign out_o.line_ok     = result_q.line_ok;

`ifndef SYNTHESIS
  a_last_byte_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && eol_q |=> res_valid_q)
    else $error("last byte of a line did not load the result register");

  a_last_byte_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && eol_q && res_valid_q && !out_o.ready |-> !in_i.ready && !step)
    else $error("last byte advanced while the result register was stalled");

  a_failed_line_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.line_ok |->
      out_o.temperature == 32'sd0 && out_o.min_time == 32'sd0 && out_o.max_time == 32'sd0)
    else $error("failed line carries nonzero field values");
`endif

endmodule

`default_nettype wire
